// ===== design/sphist_pkg.sv =====
// Shared constants, codes and types of the sphere pixel occupancy histogram.
// No dependencies; taken in by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sphist_pkg;

    // count store
    localparam int PIXELS     = 8192;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // word field widths
    localparam int COS_W     = 17;
    localparam int AZ_W      = 16;
    localparam int PIX_W     = 13;
    localparam int CNT_OUT_W = 16;
    localparam int OCC_W     = 14;

    // configuration
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;
    localparam int ROWS_W      = 7;
    localparam int COLS_W      = 8;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd32;
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd64;
    localparam logic [ROWS_W-1:0] ROWS_MAX   = 7'd64;
    localparam logic [COLS_W-1:0] COLS_MAX   = 8'd128;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // shift-add unit
    localparam int MCAND_W    = 16;
    localparam int MPLR_W     = 8;
    localparam int ACC_W      = MCAND_W + MPLR_W;
    localparam int MUL_STEPS  = MPLR_W;
    localparam int STEP_W     = $clog2(MUL_STEPS);
    localparam int FRAC_SHIFT = 16;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int PIXSUM_W   = 14;

    localparam logic signed [COS_W-1:0] COS_MIN    = -17'sd32768;
    localparam logic signed [COS_W-1:0] COS_ONE    = 17'sd32768;
    localparam logic [MCAND_W-1:0]      COS_OFFSET = 16'h8000;
    localparam logic [OCC_W-1:0]        OCC_MAX    = 14'd16383;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ROW   = 8'b0000_0100,
        S_COL   = 8'b0000_1000,
        S_PIX   = 8'b0001_0000,
        S_ADD   = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_WRITE = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_index;
        logic [CNT_OUT_W-1:0] pixel_count;
        logic                 first_hit;
        logic [OCC_W-1:0]     occupied_total;
        logic                 range_error;
    } res_t;

endpackage

`default_nettype wire

// ===== design/sphist_if.sv =====
// Handshake channels of the histogram: point words in, result words out.
// Depends on sphist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sphist_point_if
    import sphist_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [COS_W-1:0] cos_theta;
    logic [AZ_W-1:0]         azimuth;

    modport source (output valid, output cos_theta, output azimuth, input ready);
    modport sink   (input valid, input cos_theta, input azimuth, output ready);
endinterface

interface sphist_result_if
    import sphist_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_index;
    logic [CNT_OUT_W-1:0] pixel_count;
    logic                 first_hit;
    logic [OCC_W-1:0]     occupied_total;
    logic                 range_error;

    modport source (output valid, output pixel_index, output pixel_count,
                    output first_hit, output occupied_total, output range_error,
                    input ready);
    modport sink   (input valid, input pixel_index, input pixel_count,
                    input first_hit, input occupied_total, input range_error,
                    output ready);
endinterface

`default_nettype wire

// ===== design/sphere_pixel_occupancy_histogram.sv =====
// Top level of the equal-area sphere pixel occupancy histogram.
// Depends on sphist_pkg, sphist_if (channels) and sphist_ram (count store).
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  kind   payload
//  point     in   v/r    cos_theta (s17, Q15), azimuth (u16 turn fraction)
//  result    out  v/r    pixel_index, pixel_count, first_hit,
//                        occupied_total, range_error
//  apb       in   APB    0x0 rows_cos_theta, 0x4 columns_phi
//
//  From acceptance to the next acceptance a point word goes through
//  three 8-step shift-add multiplies (row, column, row*columns) on the one
//  adder, one add of the column, one count store read and one write.
//  Out-of-range points skip to the write step and leave the store as is.
//  After reset the count store is swept to zero, one entry a cycle, all
//  PIXELS (8192) entries; no point is taken meanwhile, APB works as ever.
//  The result register lets a new point in while a result waits; a point
//  finishing while that register is still full holds in the write step.

module sphere_pixel_occupancy_histogram
    import sphist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sphist_point_if.sink          point,
    sphist_result_if.source       result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t state_reg, state_next;

    logic [ROWS_W-1:0]     rows_reg;
    logic [COLS_W-1:0]     cols_reg;
    logic [ROWS_W-1:0]     rows_eff;
    logic [COLS_W-1:0]     cols_eff;
    logic                  cfg_wr;

    logic [MCAND_W-1:0]    mcand_reg;
    logic [MPLR_W-1:0]     mplr_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [AZ_W-1:0]       az_reg;
    logic                  top_reg;
    logic                  err_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [PIXSUM_W-1:0]   pix_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic                  out_valid_reg;
    res_t                  res_reg;
    res_t                  res_next;

    logic [ACC_W-1:0]      add_a;
    logic [ACC_W-1:0]      add_b;
    logic [ACC_W-1:0]      sum;
    logic                  step_last;
    logic                  clr_last;
    logic                  in_acc;
    logic                  in_ok;
    logic [MCAND_W-1:0]    cth_u;
    logic                  pix_over;
    logic                  out_free;
    logic                  finish;
    logic                  first;
    logic                  occ_inc;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] cnt_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [COUNT_BITS-1:0] ram_wdata;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_ROWS: rows_reg <= pwdata[ROWS_W-1:0];
                REG_COLS: cols_reg <= pwdata[COLS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_ROWS: prdata = APB_DATA_W'(rows_reg);
            REG_COLS: prdata = APB_DATA_W'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // zero acts as one, oversize values clamp to the grid limit
    always_comb
    begin
        priority if (rows_reg == '0)      rows_eff = ROWS_W'(1);
        else if (rows_reg > ROWS_MAX)     rows_eff = ROWS_MAX;
        else                              rows_eff = rows_reg;

        priority if (cols_reg == '0)      cols_eff = COLS_W'(1);
        else if (cols_reg > COLS_MAX)     cols_eff = COLS_MAX;
        else                              cols_eff = cols_reg;
    end

    // ---------------------------------------------------------- input side
    assign point.ready = (state_reg == S_IDLE);
    assign in_acc      = point.valid && point.ready;
    assign in_ok       = (point.cos_theta >= COS_MIN) && (point.cos_theta <= COS_ONE);
    // cos_theta + 32768 in 16 bits; exactly +1 wraps to 0 and is caught by top_reg
    assign cth_u       = point.cos_theta[COS_W-2:0] ^ COS_OFFSET;

    // ----------------------------------------------------- shared adder
    // MSB-first shift-add: acc = 2*acc + (bit ? mcand : 0).
    // In the add step it forms row*cols + col instead.
    assign add_a = (state_reg == S_ADD) ? acc_reg : (acc_reg << 1);
    assign add_b = (state_reg == S_ADD) ? ACC_W'(col_reg)
                 : (mplr_reg[MPLR_W-1] ? ACC_W'(mcand_reg) : '0);
    assign sum   = add_a + add_b;

    assign step_last = (step_reg == STEP_W'(MUL_STEPS - 1));
    assign clr_last  = (clr_addr_reg == ADDR_W'(PIXELS - 1));
    assign pix_over  = (sum >= ACC_W'(PIXELS));

    // ------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_acc) state_next = in_ok ? S_ROW : S_WRITE;
            S_ROW:   if (step_last) state_next = S_COL;
            S_COL:   if (step_last) state_next = S_PIX;
            S_PIX:   if (step_last) state_next = S_ADD;
            S_ADD:   state_next = pix_over ? S_WRITE : S_READ;
            S_READ:  state_next = S_WRITE;
            S_WRITE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            step_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ROW || state_reg == S_COL || state_reg == S_PIX)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // -------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mcand_reg <= cth_u;
                    mplr_reg  <= MPLR_W'(rows_eff);
                    acc_reg   <= '0;
                    az_reg    <= point.azimuth;
                    top_reg   <= (point.cos_theta == COS_ONE);
                    err_reg   <= !in_ok;
                end
            end
            S_ROW:
            begin
                if (step_last)
                begin
                    row_reg   <= top_reg ? ROW_W'(rows_eff - ROWS_W'(1))
                                         : sum[FRAC_SHIFT +: ROW_W];
                    mcand_reg <= az_reg;
                    mplr_reg  <= cols_eff;
                    acc_reg   <= '0;
                end
                else
                begin
                    acc_reg  <= sum;
                    mplr_reg <= mplr_reg << 1;
                end
            end
            S_COL:
            begin
                if (step_last)
                begin
                    col_reg   <= sum[FRAC_SHIFT +: COL_W];
                    mcand_reg <= MCAND_W'(cols_eff);
                    mplr_reg  <= MPLR_W'(row_reg);
                    acc_reg   <= '0;
                end
                else
                begin
                    acc_reg  <= sum;
                    mplr_reg <= mplr_reg << 1;
                end
            end
            S_PIX:
            begin
                acc_reg  <= sum;
                mplr_reg <= mplr_reg << 1;
            end
            S_ADD:
            begin
                pix_reg <= sum[PIXSUM_W-1:0];
                if (pix_over)
                begin
                    err_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------- count store
    assign ram_re    = (state_reg == S_READ);
    assign finish    = (state_reg == S_WRITE) && out_free;
    assign ram_we    = (state_reg == S_CLEAR) || (finish && !err_reg);
    assign ram_addr  = (state_reg == S_CLEAR) ? clr_addr_reg : ADDR_W'(pix_reg);
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : cnt_next;

    sphist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PIXELS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (old_cnt)
    );

    // saturating count, first-hit and occupied total
    assign first    = (old_cnt == '0);
    assign cnt_next = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
    assign occ_inc  = !err_reg && first && (occ_reg != OCC_MAX);
    assign occ_next = occ_reg + OCC_W'(occ_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (finish)
        begin
            occ_reg <= occ_next;
        end
    end

    // ---------------------------------------------------- output side
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        res_next.range_error    = err_reg;
        res_next.occupied_total = occ_next;
        res_next.pixel_index    = err_reg ? '0 : PIX_W'(pix_reg);
        res_next.pixel_count    = err_reg ? '0 : CNT_OUT_W'(cnt_next);
        res_next.first_hit      = !err_reg && first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pixel_index    = res_reg.pixel_index;
    assign result.pixel_count    = res_reg.pixel_count;
    assign result.first_hit      = res_reg.first_hit;
    assign result.occupied_total = res_reg.occupied_total;
    assign result.range_error    = res_reg.range_error;

    // ------------------------------------------------------ assertions
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.range_error |->
            result.pixel_index == '0 && result.pixel_count == '0 && !result.first_hit)
        else $error("rejected word carries pixel fields");

    a_first_one: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.range_error && result.first_hit |->
            result.pixel_count == CNT_OUT_W'(1))
        else $error("first hit with count other than one");

    a_occ_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> occ_reg >= $past(occ_reg))
        else $error("occupied total went down");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WRITE))
        else $error("count store written outside clear or write step");

endmodule

`default_nettype wire

// ===== design/sphist_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sphist_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 8192,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== bench/sphere_pixel_occupancy_histogram_test.sv =====
// Self-checking bench for the sphere pixel occupancy histogram: directed and random
// point words against an in-bench binning model, with APB grid changes between phases.
// Depends on sphist_pkg, sphist_if and the RTL top level.
`timescale 1ns / 1ps

module sphere_pixel_occupancy_histogram_test;
    import sphist_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          ITEMS_PHASE  = 229;  // eight random phases, ~1850 words in all
    localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int          TAIL_CYCLES  = 40;   // idle wait before the final check

    typedef struct packed {
        logic signed [COS_W-1:0] cos_theta;
        logic [AZ_W-1:0]         azimuth;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sphist_point_if  point_ch ();
    sphist_result_if result_ch ();

    sphere_pixel_occupancy_histogram uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Binning model: its own copy of the grid registers and count store.
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0]     grid_rows_reg;
    logic [COLS_W-1:0]     grid_cols_reg;
    logic [COUNT_BITS-1:0] bin_counts [PIXELS];
    logic [OCC_W-1:0]      occupied_bins;

    // Work out the result word of one point and update the model state.
    // Saturation of a pixel count is modelled, though a run this short
    // cannot put 65535 points into one pixel.
    function automatic res_t bin_point(input logic signed [COS_W-1:0] cth,
                                       input logic [AZ_W-1:0] az);
        res_t r;
        int   rows;
        int   cols;
        int   c;
        int   row;
        int   col;
        int   pix;
        r = '0;
        r.occupied_total = occupied_bins;
        r.range_error    = 1'b1;
        // a zero register acts as one, an oversized one as the maximum
        rows = (grid_rows_reg == 0) ? 1 : (grid_rows_reg > ROWS_MAX) ? int'(ROWS_MAX)
                                                                    : int'(grid_rows_reg);
        cols = (grid_cols_reg == 0) ? 1 : (grid_cols_reg > COLS_MAX) ? int'(COLS_MAX)
                                                                    : int'(grid_cols_reg);
        c = int'(cth);
        if (c < -32768 || c > 32768)
            return r;
        // cos(theta) of exactly one belongs to the top row
        row = (c == 32768) ? rows - 1 : ((c + 32768) * rows) >>> 16;
        col = (int'(az) * cols) >>> 16;
        pix = col + row * cols;
        if (pix >= PIXELS)
            return r;
        if (bin_counts[pix] == 0 && occupied_bins != OCC_MAX)
            occupied_bins = occupied_bins + 1'b1;
        r.first_hit = (bin_counts[pix] == 0);
        if (bin_counts[pix] != {COUNT_BITS{1'b1}})
            bin_counts[pix] = bin_counts[pix] + 1'b1;
        r.pixel_index    = PIX_W'(pix);
        r.pixel_count    = CNT_OUT_W'(bin_counts[pix]);
        r.occupied_total = occupied_bins;
        r.range_error    = 1'b0;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int draw_idle();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Recently sent points, reused so that the larger grids see repeat hits too.
    point_t recent_points [8];

    function automatic point_t random_point();
        point_t      p;
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // out of range, anywhere in the 17-bit field
            if ($urandom_range(0, 1) != 0)
                v = int'($urandom_range(32769, 65535));
            else
                v = -int'($urandom_range(32769, 65536));
        end
        else if (pick < 14) begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32768;
                2:       v = 32767;
                default: v = 0;
            endcase
        end
        else if (pick < 34) begin
            return recent_points[$urandom_range(0, 7)];
        end
        else begin
            v = int'($urandom_range(0, 65536)) - 32768;
        end
        p.cos_theta = COS_W'(v);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            p.azimuth = '0;
        else if (pick < 6)
            p.azimuth = '1;
        else
            p.azimuth = AZ_W'($urandom_range(0, 65535));
        recent_points[$urandom_range(0, 7)] = p;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, driver and monitor
    // ------------------------------------------------------------------
    point_t      points_to_send [$];
    res_t        predicted_results [$];
    int unsigned points_queued;
    int unsigned points_accepted;
    int unsigned results_checked;
    int unsigned rejects_seen;
    int unsigned first_hits_seen;
    int unsigned mismatches;
    int unsigned reg_errors;
    int unsigned grids_used;
    int unsigned hold_requests;
    bit          gaps_on;
    bit          stalls_on;

    // ------------------------------------------------------------------
    // Point driver: offers queued words, predicts each one as it is taken.
    // valid gets exactly one nonblocking assignment per edge.
    // ------------------------------------------------------------------
    int gap_left;

    always @(posedge clk) begin : point_driver
        logic   offer;
        point_t upcoming;
        if (!rst_n) begin
            point_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else begin
            offer = point_ch.valid;
            if (point_ch.valid && point_ch.ready) begin
                predicted_results.push_back(bin_point(point_ch.cos_theta, point_ch.azimuth));
                points_accepted++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (points_to_send.size() != 0) begin
                    upcoming = points_to_send.pop_front();
                    point_ch.cos_theta <= upcoming.cos_theta;
                    point_ch.azimuth   <= upcoming.azimuth;
                    offer = 1'b1;
                    if (gaps_on)
                        gap_left = draw_idle();
                end
            end
            point_ch.valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stalls plus, on request, one long hold-off
    // counted here so the block backs up into its point input.
    // ------------------------------------------------------------------
    int          stall_left;
    int          hold_left;
    int unsigned holds_done;

    always @(posedge clk) begin : result_monitor
        res_t want;
        logic take;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            holds_done = 0;
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with none expected: pixel_index %0d",
                           result_ch.pixel_index);
                    mismatches++;
                end
                else begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    if (result_ch.range_error === 1'b1) rejects_seen++;
                    if (result_ch.first_hit === 1'b1) first_hits_seen++;
                    if (result_ch.pixel_index !== want.pixel_index) begin
                        $error("pixel_index: expected %0d, got %0d",
                               want.pixel_index, result_ch.pixel_index);
                        mismatches++;
                    end
                    if (result_ch.pixel_count !== want.pixel_count) begin
                        $error("pixel_count: expected %0d, got %0d",
                               want.pixel_count, result_ch.pixel_count);
                        mismatches++;
                    end
                    if (result_ch.first_hit !== want.first_hit) begin
                        $error("first_hit: expected %0d, got %0d",
                               want.first_hit, result_ch.first_hit);
                        mismatches++;
                    end
                    if (result_ch.occupied_total !== want.occupied_total) begin
                        $error("occupied_total: expected %0d, got %0d",
                               want.occupied_total, result_ch.occupied_total);
                        mismatches++;
                    end
                    if (result_ch.range_error !== want.range_error) begin
                        $error("range_error: expected %0d, got %0d",
                               want.range_error, result_ch.range_error);
                        mismatches++;
                    end
                end
            end
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end
            else begin
                take = 1'b1;
                if (stalls_on)
                    stall_left = draw_idle();
            end
            result_ch.ready <= take;
        end
    end

    // Run limit
    int unsigned cycle_count;

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL sphere_pixel_occupancy_histogram");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB access: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------
    task automatic reg_access(input logic sel, input logic wr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Set the grid (junk in the unused upper bits), mirror it in the model
    // and read both registers back.
    task automatic set_grid(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] wr_word;
        wr_word = APB_DATA_W'($urandom);
        wr_word[ROWS_W-1:0] = rows;
        reg_access(REG_ROWS, 1'b1, wr_word, rd);
        grid_rows_reg = rows;
        wr_word = APB_DATA_W'($urandom);
        wr_word[COLS_W-1:0] = cols;
        reg_access(REG_COLS, 1'b1, wr_word, rd);
        grid_cols_reg = cols;
        reg_access(REG_ROWS, 1'b0, '0, rd);
        if (rd[ROWS_W-1:0] !== rows) begin
            $error("rows_cos_theta: expected %0d, got %0d", rows, rd[ROWS_W-1:0]);
            reg_errors++;
        end
        reg_access(REG_COLS, 1'b0, '0, rd);
        if (rd[COLS_W-1:0] !== cols) begin
            $error("columns_phi: expected %0d, got %0d", cols, rd[COLS_W-1:0]);
            reg_errors++;
        end
        grids_used++;
    endtask

    task automatic send_point(input int cth, input int az);
        point_t p;
        p.cos_theta = COS_W'(cth);
        p.azimuth   = AZ_W'(az);
        points_to_send.push_back(p);
        points_queued++;
    endtask

    // Wait until every queued word has been taken and answered.
    task automatic drain();
        while (points_accepted != points_queued || predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [APB_DATA_W-1:0] rd;
        logic [ROWS_W-1:0]     rows;
        logic [COLS_W-1:0]     cols;
        int                    half;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        point_ch.valid     = 1'b0;
        point_ch.cos_theta = '0;
        point_ch.azimuth   = '0;
        result_ch.ready    = 1'b0;
        grid_rows_reg      = ROWS_RESET;
        grid_cols_reg      = COLS_RESET;
        occupied_bins      = '0;
        foreach (bin_counts[i]) bin_counts[i] = '0;
        foreach (recent_points[i]) recent_points[i] = '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values; APB is live while the count store is being cleared
        reg_access(REG_ROWS, 1'b0, '0, rd);
        if (rd[ROWS_W-1:0] !== ROWS_RESET) begin
            $error("rows_cos_theta: expected %0d, got %0d", ROWS_RESET, rd[ROWS_W-1:0]);
            reg_errors++;
        end
        reg_access(REG_COLS, 1'b0, '0, rd);
        if (rd[COLS_W-1:0] !== COLS_RESET) begin
            $error("columns_phi: expected %0d, got %0d", COLS_RESET, rd[COLS_W-1:0]);
            reg_errors++;
        end

        // default 32 x 64 grid: field extremes, top row, out-of-range values
        send_point(-32768, 0);
        send_point(32768, 65535);      // exactly one: top row
        send_point(32767, 65535);
        send_point(0, 32768);
        send_point(-65536, 0);         // most negative field value
        send_point(-32769, 100);       // just below -1
        send_point(32769, 200);        // just above 1
        send_point(65535, 65535);      // largest positive field value
        send_point(-32768, 0);         // same pixel again, no first hit
        drain();

        // zero registers act as a 1 x 1 grid
        set_grid('0, '0);
        send_point(32768, 0);
        send_point(-32768, 65535);
        send_point(-1, 1);
        drain();

        // oversized registers clamp to 64 x 128: last pixel reached twice
        set_grid('1, '1);
        send_point(32768, 65535);
        send_point(-32768, 0);
        send_point(32767, 65535);
        send_point(-65536, 65535);
        drain();

        // random phases over a spread of grids
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin rows = ROWS_MAX; cols = COLS_MAX; end
                1:       begin rows = 7'd1;     cols = 8'd1;     end
                2:       begin rows = '1;       cols = 8'd3;     end
                3:       begin rows = '0;       cols = COLS_MAX; end
                4:       begin rows = ROWS_MAX; cols = '0;       end
                7:       begin rows = ROWS_RESET; cols = COLS_RESET; end
                default: begin
                    rows = ROWS_W'($urandom_range(0, 127));
                    cols = COLS_W'($urandom_range(0, 255));
                end
            endcase
            set_grid(rows, cols);
            // phases 1 and 5 run with no idling on either side
            gaps_on   = (phase != 1 && phase != 5);
            stalls_on = (phase != 1 && phase != 5);
            half = ITEMS_PHASE / 2;
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                points_to_send.push_back(random_point());
                points_queued++;
                // mid-phase pause: sender waits for every result
                if (phase == 3 && n == half)
                    drain();
            end
            if (phase == 0) begin
                // long hold-off on the result side while points keep coming
                while (points_accepted + 150 > points_queued)
                    @(posedge clk);
                hold_requests++;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0) begin
            $error("%0d result words never arrived", predicted_results.size());
            mismatches++;
        end

        $display("Run covered %0d point words (%0d rejected, %0d first hits) on %0d grids.",
                 points_accepted, rejects_seen, first_hits_seen, grids_used + 1);
        $display("%0d result words checked, %0d field mismatches, %0d register errors.",
                 results_checked, mismatches, reg_errors);
        if (mismatches == 0 && reg_errors == 0)
            $display("PASS sphere_pixel_occupancy_histogram");
        else
            $display("FAIL sphere_pixel_occupancy_histogram");
        $finish;
    end

endmodule

// ===== sphere_pixel_occupancy_histogram.f =====
design/sphist_pkg.sv
design/sphist_if.sv
design/sphist_ram.sv
design/sphere_pixel_occupancy_histogram.sv
bench/sphere_pixel_occupancy_histogram_test.sv
